// ----- sv/lav_pkg.sv -----
// Shared types and constants for the look-at view matrix pipeline.
// No dependencies; every other file in this folder imports it.
package lav_pkg;

    localparam int XW        = 32;               // port field width
    localparam int AXIS_FRAC = 30;               // Q2.30 axis entries
    localparam int VW        = 64;               // vector component width into a normalizer
    localparam int MW        = 30;               // normalized magnitude width
    localparam int SQW       = 2 * MW + 2;       // sum of three squares
    localparam int LW        = MW + 1;           // root (vector length) width
    localparam int QW        = MW + 1;           // quotient width
    localparam int NW        = MW + AXIS_FRAC + 1; // rounded dividend width
    localparam int PAY_W     = 6 * XW;           // side payload carried through a normalizer

    localparam logic [XW-1:0] ONE_AXIS = XW'(1) << AXIS_FRAC;
    localparam logic [VW-1:0] HALF_LSB = VW'(1) << (AXIS_FRAC - 1);

    typedef logic [2:0][XW-1:0] vec3_t;
    typedef logic [2:0][VW-1:0] wvec3_t;

endpackage

// ----- sv/lav_sqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
// Depends on lav_pkg.
module lav_sqrt
    import lav_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_vld,
    input  logic [SQW-1:0] in_n,
    input  logic [PW-1:0]  in_pay,
    output logic           out_vld,
    output logic [LW-1:0]  out_root,
    output logic [PW-1:0]  out_pay
);

    localparam int RW = LW + 1;

    logic           vld_reg  [LW];
    logic [SQW-1:0] n_reg    [LW];
    logic [RW-1:0]  rem_reg  [LW];
    logic [LW-1:0]  root_reg [LW];
    logic [PW-1:0]  pay_reg  [LW];

    for (genvar k = 0; k < LW; k++) begin : g_step
        logic           v_in;
        logic [SQW-1:0] n_in;
        logic [RW-1:0]  r_in;
        logic [LW-1:0]  q_in;
        logic [PW-1:0]  p_in;
        logic [RW+1:0]  rt;
        logic [RW+1:0]  trial;
        logic [RW-1:0]  rem_next;
        logic [LW-1:0]  root_next;

        if (k == 0) begin : g_first
            assign v_in = in_vld;
            assign n_in = in_n;
            assign r_in = '0;
            assign q_in = '0;
            assign p_in = in_pay;
        end else begin : g_rest
            assign v_in = vld_reg[k-1];
            assign n_in = n_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = root_reg[k-1];
            assign p_in = pay_reg[k-1];
        end

        // bring down two bits, try root*4+1
        always_comb begin
            rt    = {r_in, n_in[SQW-1 -: 2]};
            trial = {1'b0, q_in, 2'b01};
            if (rt >= trial) begin
                rem_next  = RW'(rt - trial);
                root_next = {q_in[LW-2:0], 1'b1};
            end else begin
                rem_next  = rt[RW-1:0];
                root_next = {q_in[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                n_reg[k]    <= {n_in[SQW-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                pay_reg[k]  <= p_in;
            end
        end
    end

    assign out_vld  = vld_reg[LW-1];
    assign out_root = root_reg[LW-1];
    assign out_pay  = pay_reg[LW-1];

endmodule

// ----- sv/lav_div.sv -----
// Pipelined restoring divider: three dividends over one shared divisor,
// one quotient bit per stage. Depends on lav_pkg.
module lav_div
    import lav_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_vld,
    input  logic [2:0][NW-1:0]  in_num,
    input  logic [LW-1:0]       in_den,
    input  logic [PW-1:0]       in_pay,
    output logic                out_vld,
    output logic [2:0][QW-1:0]  out_quo,
    output logic [PW-1:0]       out_pay
);

    logic                vld_reg [QW];
    logic [2:0][QW-1:0]  low_reg [QW];   // dividend bits shift out, quotient bits shift in
    logic [2:0][LW-1:0]  rem_reg [QW];
    logic [LW-1:0]       den_reg [QW];
    logic [PW-1:0]       pay_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic               v_in;
        logic [2:0][QW-1:0] l_in;
        logic [2:0][LW-1:0] r_in;
        logic [LW-1:0]      d_in;
        logic [PW-1:0]      p_in;
        logic [2:0][QW-1:0] low_next;
        logic [2:0][LW-1:0] rem_next;
        logic [LW:0]        rt;

        if (k == 0) begin : g_first
            assign v_in = in_vld;
            assign d_in = in_den;
            assign p_in = in_pay;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign r_in[i] = LW'(in_num[i][NW-1:QW]);
                assign l_in[i] = in_num[i][QW-1:0];
            end
        end else begin : g_rest
            assign v_in = vld_reg[k-1];
            assign l_in = low_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign p_in = pay_reg[k-1];
        end

        // trial subtract per lane
        always_comb begin
            rt       = '0;
            low_next = '0;
            rem_next = '0;
            for (int i = 0; i < 3; i++) begin
                rt = {r_in[i], l_in[i][QW-1]};
                if (rt >= {1'b0, d_in}) begin
                    rem_next[i] = LW'(rt - {1'b0, d_in});
                    low_next[i] = {l_in[i][QW-2:0], 1'b1};
                end else begin
                    rem_next[i] = rt[LW-1:0];
                    low_next[i] = {l_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                low_reg[k] <= low_next;
                rem_reg[k] <= rem_next;
                den_reg[k] <= d_in;
                pay_reg[k] <= p_in;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign out_quo = low_reg[QW-1];
    assign out_pay = pay_reg[QW-1];

endmodule

// ----- sv/lav_unit.sv -----
// Vector normalizer: scales a 3-vector to a Q2.30 unit vector (zero stays zero).
// Depends on lav_pkg, lav_sqrt and lav_div.
module lav_unit
    import lav_pkg::*;
#(
    parameter int PW = PAY_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_vld,
    input  wvec3_t        in_vec,
    input  logic [PW-1:0] in_pay,
    output logic          out_vld,
    output vec3_t         out_axis,
    output logic [PW-1:0] out_pay
);

    localparam int SPW = 3 * MW + 4 + PW;
    localparam int DPW = 4 + PW;

    // stage 1: magnitudes and signs
    wvec3_t        s1_mag_next;
    logic          s1_vld_reg;
    wvec3_t        s1_mag_reg;
    logic [2:0]    s1_neg_reg;
    logic [PW-1:0] s1_pay_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_mag_next[i] = in_vec[i][VW-1] ? (~in_vec[i] + VW'(1)) : in_vec[i];
        end
    end

    // stage 2: leading zero bytes of the combined magnitude
    logic [VW-1:0] s2_or;
    logic [2:0]    s2_hi_next;
    logic          s2_found;
    logic          s2_vld_reg;
    wvec3_t        s2_mag_reg;
    logic [VW-1:0] s2_or_reg;
    logic [2:0]    s2_hi_reg;
    logic          s2_zero_reg;
    logic [2:0]    s2_neg_reg;
    logic [PW-1:0] s2_pay_reg;

    always_comb begin
        s2_or      = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        s2_hi_next = '0;
        s2_found   = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (!s2_found && s2_or[b*8 +: 8] != 8'h00) begin
                s2_hi_next = 3'(7 - b);
                s2_found   = 1'b1;
            end
        end
    end

    // stage 3: coarse byte shift
    logic          s3_vld_reg;
    wvec3_t        s3_mag_reg;
    logic [VW-1:0] s3_or_reg;
    logic          s3_zero_reg;
    logic [2:0]    s3_neg_reg;
    logic [PW-1:0] s3_pay_reg;

    // stage 4: fine shift, keep the top MW bits (low bits truncated)
    logic [2:0]           s4_lo;
    logic                 s4_found;
    wvec3_t               s4_sh;
    logic [2:0][MW-1:0]   s4_n_next;
    logic                 s4_vld_reg;
    logic [2:0][MW-1:0]   s4_n_reg;
    logic                 s4_zero_reg;
    logic [2:0]           s4_neg_reg;
    logic [PW-1:0]        s4_pay_reg;

    always_comb begin
        s4_lo    = '0;
        s4_found = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (!s4_found && s3_or_reg[VW-8+b]) begin
                s4_lo    = 3'(7 - b);
                s4_found = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            s4_sh[i]     = s3_mag_reg[i] << s4_lo;
            s4_n_next[i] = s4_sh[i][VW-1 -: MW];
        end
    end

    // stage 5: squares
    logic                 s5_vld_reg;
    logic [2:0][2*MW-1:0] s5_sq_reg;
    logic [2:0][MW-1:0]   s5_n_reg;
    logic                 s5_zero_reg;
    logic [2:0]           s5_neg_reg;
    logic [PW-1:0]        s5_pay_reg;

    // stage 6: sum of squares
    logic                 s6_vld_reg;
    logic [SQW-1:0]       s6_sum_reg;
    logic [2:0][MW-1:0]   s6_n_reg;
    logic                 s6_zero_reg;
    logic [2:0]           s6_neg_reg;
    logic [PW-1:0]        s6_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end else if (ce) begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= {in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};
            s1_pay_reg  <= in_pay;

            s2_mag_reg  <= s1_mag_reg;
            s2_or_reg   <= s2_or;
            s2_hi_reg   <= s2_hi_next;
            s2_zero_reg <= (s2_or == '0);
            s2_neg_reg  <= s1_neg_reg;
            s2_pay_reg  <= s1_pay_reg;

            for (int i = 0; i < 3; i++) begin
                s3_mag_reg[i] <= s2_mag_reg[i] << {s2_hi_reg, 3'b000};
            end
            s3_or_reg   <= s2_or_reg << {s2_hi_reg, 3'b000};
            s3_zero_reg <= s2_zero_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_pay_reg  <= s2_pay_reg;

            s4_n_reg    <= s4_n_next;
            s4_zero_reg <= s3_zero_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_pay_reg  <= s3_pay_reg;

            for (int i = 0; i < 3; i++) begin
                s5_sq_reg[i] <= s4_n_reg[i] * s4_n_reg[i];
            end
            s5_n_reg    <= s4_n_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_pay_reg  <= s4_pay_reg;

            s6_sum_reg  <= SQW'(s5_sq_reg[0]) + SQW'(s5_sq_reg[1]) + SQW'(s5_sq_reg[2]);
            s6_n_reg    <= s5_n_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_neg_reg  <= s5_neg_reg;
            s6_pay_reg  <= s5_pay_reg;
        end
    end

    // length
    logic               sq_vld;
    logic [LW-1:0]      sq_root;
    logic [SPW-1:0]     sq_pay;
    logic [2:0][MW-1:0] sq_n;
    logic [2:0]         sq_neg;
    logic               sq_zero;
    logic [PW-1:0]      sq_opay;

    lav_sqrt #(.PW(SPW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (s6_vld_reg),
        .in_n     (s6_sum_reg),
        .in_pay   ({s6_n_reg, s6_neg_reg, s6_zero_reg, s6_pay_reg}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_pay  (sq_pay)
    );

    assign {sq_n, sq_neg, sq_zero, sq_opay} = sq_pay;

    // stage 7: rounded dividends, m * 2^30 + len / 2
    logic               s7_vld_reg;
    logic [2:0][NW-1:0] s7_num_reg;
    logic [LW-1:0]      s7_den_reg;
    logic [DPW-1:0]     s7_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_vld_reg <= 1'b0;
        end else if (ce) begin
            s7_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s7_num_reg[i] <= NW'({sq_n[i], {AXIS_FRAC{1'b0}}}) + NW'(sq_root >> 1);
            end
            s7_den_reg <= sq_root;
            s7_pay_reg <= {sq_neg, sq_zero, sq_opay};
        end
    end

    logic               dv_vld;
    logic [2:0][QW-1:0] dv_quo;
    logic [DPW-1:0]     dv_pay;
    logic [2:0]         dv_neg;
    logic               dv_zero;
    logic [PW-1:0]      dv_opay;

    lav_div #(.PW(DPW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (s7_vld_reg),
        .in_num  (s7_num_reg),
        .in_den  (s7_den_reg),
        .in_pay  (s7_pay_reg),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_pay (dv_pay)
    );

    assign {dv_neg, dv_zero, dv_opay} = dv_pay;

    // stage 8: restore signs, zero vector gives zero axis
    logic          s8_vld_reg;
    vec3_t         s8_axis_reg;
    logic [PW-1:0] s8_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_vld_reg <= 1'b0;
        end else if (ce) begin
            s8_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_zero) begin
                    s8_axis_reg[i] <= '0;
                end else if (dv_neg[i]) begin
                    s8_axis_reg[i] <= XW'(-{1'b0, dv_quo[i]});
                end else begin
                    s8_axis_reg[i] <= XW'({1'b0, dv_quo[i]});
                end
            end
            s8_pay_reg <= dv_opay;
        end
    end

    assign out_vld  = s8_vld_reg;
    assign out_axis = s8_axis_reg;
    assign out_pay  = s8_pay_reg;

endmodule

// ----- sv/look_at_view_matrix.sv -----
// Top level of the right-handed look-at view matrix pipeline.
// Depends on lav_pkg and lav_unit (which uses lav_sqrt and lav_div).
//
// Usage:
//   Input beat (s_valid/s_ready): eye, target and up vectors, signed Q16.16.
//   Result beat (m_valid/m_ready): side, true-up and back axes in signed Q2.30
//   and the three translation entries, saturated, in the input format.
//   The implied bottom row 0,0,0,1 is not sent. One result per input beat.
// Throughput: one beat per cycle when not stalled. The depth is set by the two
//   normalizers, each holding a 31-stage square root and a 31-stage divider,
//   plus the multiply stages of the cross products, true-up axis and translation.
// Reset (aresetn low, synchronous): all in-flight beats are dropped and
//   m_valid falls; data registers are not cleared.
// Stalls: the result register holds a valid beat while m_ready is low. The
//   pipeline keeps moving (and s_ready stays high) until a finished beat
//   reaches its last stage behind the held result; then the whole pipeline
//   freezes, losing nothing, and s_ready drops until the result is taken.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [XW-1:0] s_eye_x,
    input  logic signed [XW-1:0] s_eye_y,
    input  logic signed [XW-1:0] s_eye_z,
    input  logic signed [XW-1:0] s_target_x,
    input  logic signed [XW-1:0] s_target_y,
    input  logic signed [XW-1:0] s_target_z,
    input  logic signed [XW-1:0] s_up_x,
    input  logic signed [XW-1:0] s_up_y,
    input  logic signed [XW-1:0] s_up_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [XW-1:0] m_side_x,
    output logic signed [XW-1:0] m_side_y,
    output logic signed [XW-1:0] m_side_z,
    output logic signed [XW-1:0] m_upaxis_x,
    output logic signed [XW-1:0] m_upaxis_y,
    output logic signed [XW-1:0] m_upaxis_z,
    output logic signed [XW-1:0] m_back_x,
    output logic signed [XW-1:0] m_back_y,
    output logic signed [XW-1:0] m_back_z,
    output logic signed [XW-1:0] m_shift_x,
    output logic signed [XW-1:0] m_shift_y,
    output logic signed [XW-1:0] m_shift_z
);

    typedef struct packed {
        vec3_t eye;
        vec3_t up;
    } eu_t;

    typedef struct packed {
        vec3_t eye;
        vec3_t back;
    } eb_t;

    localparam logic [33:0] SAT_POS_MAG = 34'h0_7FFF_FFFF;
    localparam logic [33:0] SAT_NEG_MAG = 34'h0_8000_0000;

    logic ce;
    logic out_free;
    logic d4_vld_reg;

    // global advance: freeze only when a finished beat is blocked
    assign out_free = !m_valid || m_ready;
    assign ce       = out_free || !d4_vld_reg;
    assign s_ready  = ce;

    // input stage: eye minus target
    vec3_t  in_eye;
    vec3_t  in_tgt;
    logic   t0_vld_reg;
    wvec3_t t0_d_reg;
    eu_t    t0_pay_reg;

    assign in_eye = {s_eye_z, s_eye_y, s_eye_x};
    assign in_tgt = {s_target_z, s_target_y, s_target_x};

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                t0_d_reg[i] <= {{(VW-XW){in_eye[i][XW-1]}}, in_eye[i]}
                             - {{(VW-XW){in_tgt[i][XW-1]}}, in_tgt[i]};
            end
            t0_pay_reg.eye <= in_eye;
            t0_pay_reg.up  <= {s_up_z, s_up_y, s_up_x};
        end
    end

    // back axis
    logic          u1_vld;
    vec3_t         u1_back;
    logic [PAY_W-1:0] u1_pay;
    eu_t           u1_eu;

    lav_unit #(.PW(PAY_W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (t0_vld_reg),
        .in_vec   (t0_d_reg),
        .in_pay   (t0_pay_reg),
        .out_vld  (u1_vld),
        .out_axis (u1_back),
        .out_pay  (u1_pay)
    );

    assign u1_eu = eu_t'(u1_pay);

    // up x back, exact
    logic                   c1_vld_reg;
    logic signed [VW-1:0]   c1_p_reg [6];
    eb_t                    c1_pay_reg;
    logic                   c2_vld_reg;
    wvec3_t                 c2_c_reg;
    eb_t                    c2_pay_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            c1_p_reg[0] <= $signed(u1_eu.up[1]) * $signed(u1_back[2]);
            c1_p_reg[1] <= $signed(u1_eu.up[2]) * $signed(u1_back[1]);
            c1_p_reg[2] <= $signed(u1_eu.up[2]) * $signed(u1_back[0]);
            c1_p_reg[3] <= $signed(u1_eu.up[0]) * $signed(u1_back[2]);
            c1_p_reg[4] <= $signed(u1_eu.up[0]) * $signed(u1_back[1]);
            c1_p_reg[5] <= $signed(u1_eu.up[1]) * $signed(u1_back[0]);
            c1_pay_reg.eye  <= u1_eu.eye;
            c1_pay_reg.back <= u1_back;

            c2_c_reg[0] <= VW'(c1_p_reg[0] - c1_p_reg[1]);
            c2_c_reg[1] <= VW'(c1_p_reg[2] - c1_p_reg[3]);
            c2_c_reg[2] <= VW'(c1_p_reg[4] - c1_p_reg[5]);
            c2_pay_reg  <= c1_pay_reg;
        end
    end

    // side axis
    logic             u2_vld;
    vec3_t            u2_side;
    logic [PAY_W-1:0] u2_pay;
    eb_t              u2_eb;

    lav_unit #(.PW(PAY_W)) u_side (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (c2_vld_reg),
        .in_vec   (c2_c_reg),
        .in_pay   (c2_pay_reg),
        .out_vld  (u2_vld),
        .out_axis (u2_side),
        .out_pay  (u2_pay)
    );

    assign u2_eb = eb_t'(u2_pay);

    // true up axis: back x side, rounded to Q2.30 and clamped
    logic                 v1_vld_reg;
    logic signed [VW-1:0] v1_p_reg [6];
    vec3_t                v1_eye_reg, v1_back_reg, v1_side_reg;
    logic                 v2_vld_reg;
    logic signed [VW-1:0] v2_x_reg [3];
    vec3_t                v2_eye_reg, v2_back_reg, v2_side_reg;
    logic                 v3_vld_reg;
    logic [XW-1:0]        v3_m_reg [3];
    logic [2:0]           v3_neg_reg;
    vec3_t                v3_eye_reg, v3_back_reg, v3_side_reg;
    logic                 v4_vld_reg;
    vec3_t                v4_up_reg;
    vec3_t                v4_eye_reg, v4_back_reg, v4_side_reg;

    logic [VW-1:0] v3_mag  [3];
    logic [VW-1:0] v3_rnd  [3];
    logic [XW-1:0] v4_clip [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v3_mag[i]  = v2_x_reg[i][VW-1] ? VW'(-v2_x_reg[i]) : VW'(v2_x_reg[i]);
            v3_rnd[i]  = (v3_mag[i] + HALF_LSB) >> AXIS_FRAC;
            v4_clip[i] = (v3_m_reg[i] > ONE_AXIS) ? ONE_AXIS : v3_m_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v1_p_reg[0] <= $signed(u2_eb.back[1]) * $signed(u2_side[2]);
            v1_p_reg[1] <= $signed(u2_eb.back[2]) * $signed(u2_side[1]);
            v1_p_reg[2] <= $signed(u2_eb.back[2]) * $signed(u2_side[0]);
            v1_p_reg[3] <= $signed(u2_eb.back[0]) * $signed(u2_side[2]);
            v1_p_reg[4] <= $signed(u2_eb.back[0]) * $signed(u2_side[1]);
            v1_p_reg[5] <= $signed(u2_eb.back[1]) * $signed(u2_side[0]);
            v1_eye_reg  <= u2_eb.eye;
            v1_back_reg <= u2_eb.back;
            v1_side_reg <= u2_side;

            v2_x_reg[0] <= v1_p_reg[0] - v1_p_reg[1];
            v2_x_reg[1] <= v1_p_reg[2] - v1_p_reg[3];
            v2_x_reg[2] <= v1_p_reg[4] - v1_p_reg[5];
            v2_eye_reg  <= v1_eye_reg;
            v2_back_reg <= v1_back_reg;
            v2_side_reg <= v1_side_reg;

            for (int i = 0; i < 3; i++) begin
                v3_m_reg[i]   <= v3_rnd[i][XW-1:0];
                v3_neg_reg[i] <= v2_x_reg[i][VW-1];
            end
            v3_eye_reg  <= v2_eye_reg;
            v3_back_reg <= v2_back_reg;
            v3_side_reg <= v2_side_reg;

            for (int i = 0; i < 3; i++) begin
                v4_up_reg[i] <= v3_neg_reg[i] ? XW'(-v4_clip[i]) : v4_clip[i];
            end
            v4_eye_reg  <= v3_eye_reg;
            v4_back_reg <= v3_back_reg;
            v4_side_reg <= v3_side_reg;
        end
    end

    // translation: -(eye . axis) >> 30, rounded and saturated
    // axis order: 0 side, 1 true up, 2 back
    logic                 d1_vld_reg;
    logic signed [VW-1:0] d1_p_reg [3][3];
    vec3_t                d1_side_reg, d1_up_reg, d1_back_reg;
    logic                 d2_vld_reg;
    logic signed [VW-1:0] d2_sum_reg [3];
    vec3_t                d2_side_reg, d2_up_reg, d2_back_reg;
    logic                 d3_vld_reg;
    logic [33:0]          d3_m_reg [3];
    logic [2:0]           d3_neg_reg;
    vec3_t                d3_side_reg, d3_up_reg, d3_back_reg;
    vec3_t                d4_shift_reg;
    vec3_t                d4_side_reg, d4_up_reg, d4_back_reg;

    vec3_t         d1_axis [3];
    logic [VW-1:0] d3_mag  [3];
    logic [VW-1:0] d3_rnd  [3];
    logic [XW-1:0] d4_sat  [3];

    assign d1_axis[0] = v4_side_reg;
    assign d1_axis[1] = v4_up_reg;
    assign d1_axis[2] = v4_back_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d3_mag[a] = d2_sum_reg[a][VW-1] ? VW'(-d2_sum_reg[a]) : VW'(d2_sum_reg[a]);
            d3_rnd[a] = (d3_mag[a] + HALF_LSB) >> AXIS_FRAC;
            if (!d3_neg_reg[a]) begin
                d4_sat[a] = (d3_m_reg[a] > SAT_POS_MAG) ? SAT_POS_MAG[XW-1:0]
                                                        : d3_m_reg[a][XW-1:0];
            end else begin
                d4_sat[a] = (d3_m_reg[a] > SAT_NEG_MAG) ? SAT_NEG_MAG[XW-1:0]
                                                        : XW'(-d3_m_reg[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    d1_p_reg[a][i] <= $signed(v4_eye_reg[i]) * $signed(d1_axis[a][i]);
                end
            end
            d1_side_reg <= v4_side_reg;
            d1_up_reg   <= v4_up_reg;
            d1_back_reg <= v4_back_reg;

            for (int a = 0; a < 3; a++) begin
                d2_sum_reg[a] <= d1_p_reg[a][0] + d1_p_reg[a][1] + d1_p_reg[a][2];
            end
            d2_side_reg <= d1_side_reg;
            d2_up_reg   <= d1_up_reg;
            d2_back_reg <= d1_back_reg;

            for (int a = 0; a < 3; a++) begin
                d3_m_reg[a]   <= d3_rnd[a][33:0];
                // negated dot product is negative when the dot is positive
                d3_neg_reg[a] <= !d2_sum_reg[a][VW-1] && (d2_sum_reg[a] != '0);
            end
            d3_side_reg <= d2_side_reg;
            d3_up_reg   <= d2_up_reg;
            d3_back_reg <= d2_back_reg;

            for (int a = 0; a < 3; a++) begin
                d4_shift_reg[a] <= d4_sat[a];
            end
            d4_side_reg <= d3_side_reg;
            d4_up_reg   <= d3_up_reg;
            d4_back_reg <= d3_back_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            v1_vld_reg <= 1'b0;
            v2_vld_reg <= 1'b0;
            v3_vld_reg <= 1'b0;
            v4_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            d4_vld_reg <= 1'b0;
        end else if (ce) begin
            t0_vld_reg <= s_valid;
            c1_vld_reg <= u1_vld;
            c2_vld_reg <= c1_vld_reg;
            v1_vld_reg <= u2_vld;
            v2_vld_reg <= v1_vld_reg;
            v3_vld_reg <= v2_vld_reg;
            v4_vld_reg <= v3_vld_reg;
            d1_vld_reg <= v4_vld_reg;
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            d4_vld_reg <= d3_vld_reg;
        end
    end

    // result register
    logic  m_valid_reg;
    vec3_t out_side_reg, out_up_reg, out_back_reg, out_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= d4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_side_reg  <= d4_side_reg;
            out_up_reg    <= d4_up_reg;
            out_back_reg  <= d4_back_reg;
            out_shift_reg <= d4_shift_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_side_x   = out_side_reg[0];
    assign m_side_y   = out_side_reg[1];
    assign m_side_z   = out_side_reg[2];
    assign m_upaxis_x = out_up_reg[0];
    assign m_upaxis_y = out_up_reg[1];
    assign m_upaxis_z = out_up_reg[2];
    assign m_back_x   = out_back_reg[0];
    assign m_back_y   = out_back_reg[1];
    assign m_back_z   = out_back_reg[2];
    assign m_shift_x  = out_shift_reg[0];
    assign m_shift_y  = out_shift_reg[1];
    assign m_shift_z  = out_shift_reg[2];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for look_at_view_matrix: an independent look-at predictor
// against the pipeline, with random idling on both beats. Depends on lav_pkg and the RTL.
module tb_top;
    import lav_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 152;

    typedef struct {
        logic signed [31:0] f [12];
    } matrix_t;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] tgt [3];
        logic signed [31:0] up [3];
    } camera_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic signed [31:0] s_up_x = '0, s_up_y = '0, s_up_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_side_x, m_side_y, m_side_z;
    logic signed [31:0] m_upaxis_x, m_upaxis_y, m_upaxis_z;
    logic signed [31:0] m_back_x, m_back_y, m_back_z;
    logic signed [31:0] m_shift_x, m_shift_y, m_shift_z;

    matrix_t expected_views [$];
    int  fail_count = 0;
    int  beats_sent = 0;
    int  views_checked = 0;
    int  send_idle_pct = 0;
    int  take_idle_pct = 0;
    int  hold_off_cycles = 0;

    string field_names [12] = '{"side_x", "side_y", "side_z", "upaxis_x", "upaxis_y",
        "upaxis_z", "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};

    look_at_view_matrix dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // shift right with ties away from zero
    function automatic logic signed [63:0] round_shift(logic signed [63:0] x, int s);
        logic [63:0] m;
        m = magnitude(x);
        m = (m + (64'd1 << (s - 1))) >> s;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to common exponent, then divide by the length in Q2.30
    function automatic void normalize(input logic signed [63:0] v [3],
                                      output logic signed [63:0] o [3]);
        logic [63:0] m [3];
        logic [63:0] top, total, len, q;
        for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (top == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (top >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            top = top >> 1;
        end
        while (top < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            top = top << 1;
        end
        total = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = floor_root(total);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << AXIS_FRAC) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [63:0] clamp_unit(logic signed [63:0] x);
        if (x > 64'sd1073741824) return 64'sd1073741824;
        if (x < -64'sd1073741824) return -64'sd1073741824;
        return x;
    endfunction

    function automatic logic signed [31:0] translation(logic signed [63:0] e [3],
                                                       logic signed [63:0] a [3]);
        logic signed [63:0] d, r;
        d = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
        r = round_shift(-d, AXIS_FRAC);
        if (r > 64'sd2147483647) return 32'sh7fffffff;
        if (r < -64'sd2147483648) return 32'sh80000000;
        return r[31:0];
    endfunction

    function automatic matrix_t predict_view(camera_t c);
        logic signed [63:0] e [3], t [3], u [3], d [3], b [3], x [3], s [3], v [3];
        matrix_t r;
        for (int i = 0; i < 3; i++) begin
            e[i] = c.eye[i];
            t[i] = c.tgt[i];
            u[i] = c.up[i];
            d[i] = e[i] - t[i];
        end
        normalize(d, b);
        x[0] = u[1] * b[2] - u[2] * b[1];
        x[1] = u[2] * b[0] - u[0] * b[2];
        x[2] = u[0] * b[1] - u[1] * b[0];
        normalize(x, s);
        v[0] = clamp_unit(round_shift(b[1] * s[2] - b[2] * s[1], AXIS_FRAC));
        v[1] = clamp_unit(round_shift(b[2] * s[0] - b[0] * s[2], AXIS_FRAC));
        v[2] = clamp_unit(round_shift(b[0] * s[1] - b[1] * s[0], AXIS_FRAC));
        for (int i = 0; i < 3; i++) begin
            r.f[i] = s[i][31:0];
            r.f[3 + i] = v[i][31:0];
            r.f[6 + i] = b[i][31:0];
        end
        r.f[9] = translation(e, s);
        r.f[10] = translation(e, v);
        r.f[11] = translation(e, b);
        return r;
    endfunction

    // ---------------- sending ----------------
    // valid drops only while idling, so it is written once per edge
    task automatic send_camera(camera_t c);
        while (($urandom_range(99) < send_idle_pct)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_eye_x <= c.eye[0];    s_eye_y <= c.eye[1];    s_eye_z <= c.eye[2];
        s_target_x <= c.tgt[0]; s_target_y <= c.tgt[1]; s_target_z <= c.tgt[2];
        s_up_x <= c.up[0];      s_up_y <= c.up[1];      s_up_z <= c.up[2];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_views.push_back(predict_view(c));
        beats_sent++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
            2: return $signed($urandom_range(32'h1ffffff)) - 32'sh1000000;
            3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            4: return $signed($urandom_range(16)) - 8;
            default: return $signed($urandom_range(32'h3ffffff)) - 32'sh2000000;
        endcase
    endfunction

    function automatic camera_t rand_camera();
        camera_t c;
        for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_coord();
            c.tgt[i] = rand_coord();
            c.up[i] = rand_coord();
        end
        case ($urandom_range(9))
            0: c.tgt = c.eye;                                  // coincident points
            1: for (int i = 0; i < 3; i++) c.up[i] = 0;        // null up
            2: for (int i = 0; i < 3; i++) c.up[i] = c.eye[i] - c.tgt[i]; // parallel up
            default: ;
        endcase
        return c;
    endfunction

    function automatic camera_t make_camera(int ex, int ey, int ez, int tx, int ty, int tz,
                                            int ux, int uy, int uz);
        camera_t c;
        c.eye = '{ex, ey, ez};
        c.tgt = '{tx, ty, tz};
        c.up = '{ux, uy, uz};
        return c;
    endfunction

    // ---------------- checking ----------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            logic signed [31:0] got [12];
            matrix_t want;
            got = '{m_side_x, m_side_y, m_side_z, m_upaxis_x, m_upaxis_y, m_upaxis_z,
                    m_back_x, m_back_y, m_back_z, m_shift_x, m_shift_y, m_shift_z};
            if (expected_views.size() == 0) begin
                $error("result beat with no pending view");
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                views_checked++;
                for (int i = 0; i < 12; i++)
                    if (got[i] !== want.f[i]) begin
                        $error("%s: expected %0d, got %0d", field_names[i], want.f[i], got[i]);
                        fail_count++;
                    end
            end
        end
    end

    // receiver: random stall, or a long counted hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        int one = 32'h10000;
        send_camera(make_camera(0, 0, one, 0, 0, 0, 0, one, 0));
        send_camera(make_camera(5 * one, 3 * one, -2 * one, one, 0, 0, 0, one, 0));
        send_camera(make_camera(one, one, one, one, one, one, 0, one, 0)); // eye on target
        send_camera(make_camera(0, 0, one, 0, 0, 0, 0, 0, 0));             // zero up
        send_camera(make_camera(0, 0, one, 0, 0, 0, 0, 0, 3 * one));       // up along back
        send_camera(make_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h7fffffff, 32'h80000000));
        send_camera(make_camera(32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h80000000, 1));
        send_camera(make_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                0, 0, 0, 1, 0, 0));                         // shift saturates
        send_camera(make_camera(1, 0, 0, 0, 0, 0, 0, 1, 0));               // tiny vectors
        send_camera(make_camera(-1, -1, -1, 0, 0, 0, -1, 1, -1));
        send_camera(make_camera(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                0, 0, 0, 32'hffffffff, 0, 0));
        send_camera(make_camera(3, 4, 0, 0, 0, 0, 0, 0, 1));
    endtask

    task automatic test_random(int count, int send_pct, int take_pct);
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        repeat (count) send_camera(rand_camera());
    endtask

    // hold the result beat long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        send_idle_pct = 0;
        take_idle_pct = 0;
        hold_off_cycles = 3 * LATENCY;
        repeat (250) send_camera(rand_camera());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 19;
        take_idle_pct = 50;
        test_directed();
        test_random(180, 19, 50);
        test_random(180, 50, 19);
        test_random(180, 0, 0);
        test_backpressure();
        s_valid <= 1'b0;
        take_idle_pct = 0;
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Covered %0d camera beats, %0d views checked: extremes, eye on target,",
                 beats_sent, views_checked);
        $display("null and parallel up, saturation, idling on both sides and long stalls.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
